// ===== sv/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stereo to mono int16 downmix core.
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int NSTG = 5;

	typedef enum logic [1:0] {
		FMT_INT16   = 2'd0,
		FMT_INT24   = 2'd1,
		FMT_INT32   = 2'd2,
		FMT_FLOAT32 = 2'd3
	} format_t;

	typedef struct packed {
		logic [NSTG-1:0] en;
		logic [NSTG-1:0] vld;
	} spm_ctl_t;

	localparam logic [14:0] SCALE     = 15'd32767;
	localparam logic [15:0] POS_FULL  = 16'h7FFF;
	localparam logic [15:0] NEG_FULL  = 16'h8001;
	localparam logic [8:0]  SHR_BASE  = 9'd151;

endpackage

// ===== sv/spm_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// spm_pipe_ctl
// Valid bits and per-stage load enables; bubbles collapse on stall.
// ----------------------------------------------------------------------------
module spm_pipe_ctl
	import spm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_stall,
	output spm_ctl_t ctl
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;
	logic [NSTG-1:0] nxt;

	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
		for (int i = NSTG-2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
		nxt[0] = in_valid;
		for (int i = 1; i < NSTG; i++) begin
			nxt[i] = vld_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= nxt[i];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule

// ===== sv/stereo_pcm_to_mono_int16_core.sv =====
// ----------------------------------------------------------------------------
// stereo_pcm_to_mono_int16_core
// Throughput: one beat per cycle while out_stall does not hold the pipeline;
// the float add, normalize/round, 24x15 multiply and final rounding each own
// a pipeline stage.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module stereo_pcm_to_mono_int16_core
	import spm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         format,
	input  logic [31:0]        left_raw,
	input  logic [31:0]        right_raw,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] mono_sample,
	output logic               last_out
);

	spm_ctl_t ctl;

	spm_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	assign in_stall  = !ctl.en[0];
	assign out_valid = ctl.vld[NSTG-1];

	// ---------------- stage 1: unpack, order, align ----------------
	logic        swap;
	logic [31:0] big, sml;
	logic        nan_a, nan_b, inf_a, inf_b, is_nan, is_inf;
	logic [23:0] m_big, m_sml;
	logic [7:0]  e_big, e_sml, dexp;
	logic [4:0]  dcap;
	logic [53:0] wide;
	logic [32:0] opl, opr;

	always_comb begin
		swap  = right_raw[30:0] > left_raw[30:0];
		big   = swap ? right_raw : left_raw;
		sml   = swap ? left_raw : right_raw;
		nan_a = (&left_raw[30:23]) && (|left_raw[22:0]);
		nan_b = (&right_raw[30:23]) && (|right_raw[22:0]);
		inf_a = (&left_raw[30:23]) && !(|left_raw[22:0]);
		inf_b = (&right_raw[30:23]) && !(|right_raw[22:0]);
		is_nan = nan_a || nan_b || (inf_a && inf_b && (left_raw[31] ^ right_raw[31]));
		is_inf = inf_a || inf_b;
		m_big = {|big[30:23], big[22:0]};
		m_sml = {|sml[30:23], sml[22:0]};
		e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		dexp  = e_big - e_sml;
		dcap  = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
		wide  = {m_sml, 3'b000, 27'd0} >> dcap;
		case (format_t'(format))
			FMT_INT16: begin
				opl = {{17{left_raw[15]}}, left_raw[15:0]};
				opr = {{17{right_raw[15]}}, right_raw[15:0]};
			end
			FMT_INT24: begin
				opl = {{9{left_raw[23]}}, left_raw[23:0]};
				opr = {{9{right_raw[23]}}, right_raw[23:0]};
			end
			default: begin
				opl = {left_raw[31], left_raw};
				opr = {right_raw[31], right_raw};
			end
		endcase
	end

	logic        sgn_s1, sub_s1, spos_s1, sneg_s1, last_s1;
	logic [1:0]  fmt_s1;
	logic [7:0]  exp_s1;
	logic [26:0] ma_s1, mb_s1;
	logic [32:0] isum_s1;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			sgn_s1  <= big[31];
			sub_s1  <= left_raw[31] ^ right_raw[31];
			spos_s1 <= is_nan || (is_inf && !big[31]);
			sneg_s1 <= !is_nan && is_inf && big[31];
			exp_s1  <= e_big;
			ma_s1   <= {m_big, 3'b000};
			mb_s1   <= wide[53:27] | {26'd0, |wide[26:0]};
			isum_s1 <= opl + opr;
			fmt_s1  <= format;
			last_s1 <= last_in;
		end
	end

	// ---------------- stage 2: add, leading zeros, int halving ----------------
	logic [27:0] raw;
	logic [4:0]  lz;
	logic [32:0] ih;
	logic [31:0] hv;
	logic [15:0] ires;

	always_comb begin
		raw = sub_s1 ? ({1'b0, ma_s1} - {1'b0, mb_s1}) : ({1'b0, ma_s1} + {1'b0, mb_s1});
		lz  = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (raw[i]) begin
				lz = 5'(27 - i);
			end
		end
		ih = isum_s1 + {32'd0, isum_s1[32]};
		hv = ih[32:1];
		case (format_t'(fmt_s1))
			FMT_INT16: ires = hv[15:0];
			FMT_INT24: ires = hv[23:8];
			default:   ires = hv[31:16];
		endcase
	end

	logic        sgn_s2, spos_s2, sneg_s2, last_s2;
	logic [1:0]  fmt_s2;
	logic [7:0]  exp_s2;
	logic [27:0] raw_s2;
	logic [4:0]  lz_s2;
	logic [15:0] ires_s2;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			sgn_s2  <= sgn_s1;
			spos_s2 <= spos_s1;
			sneg_s2 <= sneg_s1;
			exp_s2  <= exp_s1;
			raw_s2  <= raw;
			lz_s2   <= lz;
			ires_s2 <= ires;
			fmt_s2  <= fmt_s1;
			last_s2 <= last_s1;
		end
	end

	// ---------------- stage 3: normalize and round the sum ----------------
	logic [26:0] nrm;
	logic [8:0]  ne, re;
	logic [7:0]  lzm1, emax, shamt;
	logic [24:0] m25;
	logic [23:0] rmant;
	logic        rup, over, special;

	always_comb begin
		lzm1  = {3'd0, lz_s2} - 8'd1;
		emax  = exp_s2 - 8'd1;
		shamt = (lzm1 < emax) ? lzm1 : emax;
		if (raw_s2[27]) begin
			nrm = {raw_s2[27:2], raw_s2[1] | raw_s2[0]};
			ne  = {1'b0, exp_s2} + 9'd1;
		end else begin
			nrm = raw_s2[26:0] << ((shamt > 8'd27) ? 5'd27 : shamt[4:0]);
			ne  = {1'b0, exp_s2} - {1'b0, shamt};
		end
		rup   = nrm[2] && (nrm[1] || nrm[0] || nrm[3]);
		m25   = {1'b0, nrm[26:3]} + {24'd0, rup};
		rmant = m25[24] ? m25[24:1] : m25[23:0];
		re    = m25[24] ? ne + 9'd1 : ne;
		over  = re >= 9'd128;
		special = spos_s2 || sneg_s2;
	end

	logic        sgn_s3, cpos_s3, cneg_s3, zero_s3, last_s3;
	logic [1:0]  fmt_s3;
	logic [7:0]  e_s3;
	logic [23:0] mant_s3;
	logic [15:0] ires_s3;

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			sgn_s3  <= sgn_s2;
			cpos_s3 <= spos_s2 || (!special && over && !sgn_s2);
			cneg_s3 <= sneg_s2 || (!special && over && sgn_s2);
			zero_s3 <= re <= 9'd1;
			e_s3    <= re[7:0];
			mant_s3 <= rmant;
			ires_s3 <= ires_s2;
			fmt_s3  <= fmt_s2;
			last_s3 <= last_s2;
		end
	end

	// ---------------- stage 4: scale by 32767 ----------------
	logic        sgn_s4, cpos_s4, cneg_s4, zero_s4, last_s4;
	logic [1:0]  fmt_s4;
	logic [7:0]  e_s4;
	logic [38:0] prod_s4;
	logic [15:0] ires_s4;

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			sgn_s4  <= sgn_s3;
			cpos_s4 <= cpos_s3;
			cneg_s4 <= cneg_s3;
			zero_s4 <= zero_s3;
			e_s4    <= e_s3;
			prod_s4 <= {15'd0, mant_s3} * {24'd0, SCALE};
			ires_s4 <= ires_s3;
			fmt_s4  <= fmt_s3;
			last_s4 <= last_s3;
		end
	end

	// ---------------- stage 5: round product, truncate, select ----------------
	logic        hi, g, st;
	logic [23:0] keep;
	logic [24:0] r25, mag;
	logic [8:0]  shr;
	logic [15:0] fres, sres;

	always_comb begin
		hi   = prod_s4[38];
		keep = hi ? prod_s4[38:15] : prod_s4[37:14];
		g    = hi ? prod_s4[14] : prod_s4[13];
		st   = hi ? |prod_s4[13:0] : |prod_s4[12:0];
		r25  = {1'b0, keep} + {24'd0, g && (st || keep[0])};
		shr  = SHR_BASE - {1'b0, e_s4} - (hi ? 9'd15 : 9'd14);
		mag  = r25 >> ((shr > 9'd31) ? 5'd31 : shr[4:0]);
		sres = sgn_s4 ? (16'd0 - mag[15:0]) : mag[15:0];
		if (cpos_s4) begin
			fres = POS_FULL;
		end else if (cneg_s4) begin
			fres = NEG_FULL;
		end else if (zero_s4) begin
			fres = 16'd0;
		end else begin
			fres = sres;
		end
	end

	logic [15:0] mono_s5;
	logic        last_s5;

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			mono_s5 <= (format_t'(fmt_s4) == FMT_FLOAT32) ? fres : ires_s4;
			last_s5 <= last_s4;
		end
	end

	assign mono_sample = mono_s5;
	assign last_out    = last_s5;

endmodule

// ===== sv/spm_checker.sv =====
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks for the downmix core, bound to the top level.
// ----------------------------------------------------------------------------
module spm_checker
	import spm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  format,
	input logic [31:0] left_raw,
	input logic [31:0] right_raw,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] mono_sample,
	input logic        last_out
);

	// input only backs up when the output beat is held
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output beat");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("beat lost in pipeline");

	// equal int16 channels average to themselves
	a_int16_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall && format == FMT_INT16
		&& left_raw[15:0] == right_raw[15:0]) ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall |=> mono_sample == $past(left_raw[15:0], 5))
		else $error("int16 average mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(mono_sample)
		&& $stable(last_out))
		else $error("held output beat changed");

endmodule

bind stereo_pcm_to_mono_int16_core spm_checker u_spm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.format      (format),
	.left_raw    (left_raw),
	.right_raw   (right_raw),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.mono_sample (mono_sample),
	.last_out    (last_out)
);
